@@ hdl/itfmt_pkg.sv @@
// Shared types, constants and character lookup for the integer-to-ASCII formatter.
`timescale 1ns / 1ps

package itfmt_pkg;

    localparam int C_BIN_W   = 64;
    localparam int C_DIGITS  = 20;
    localparam int C_DIG_W   = 4 * C_DIGITS;
    localparam int C_CNT_W   = 6;

    localparam logic [1:0] C_MODE_DEC   = 2'd0;
    localparam logic [1:0] C_MODE_HEXLO = 2'd1;
    localparam logic [1:0] C_MODE_HEXUP = 2'd2;
    localparam logic [1:0] C_MODE_PTR   = 2'd3;

    localparam logic [7:0] C_CHR_MINUS = 8'h2D;
    localparam logic [7:0] C_CHR_ZERO  = 8'h30;
    localparam logic [7:0] C_CHR_X     = 8'h78;

    typedef struct packed {
        logic [1:0]         mode;
        logic [C_BIN_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out;

    // Map one digit to its ASCII code, letters in the chosen case
    function automatic logic [7:0] f_digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        begin
            if (nib < 4'd10) begin
                c = C_CHR_ZERO + {4'd0, nib};
            end else if (upper) begin
                c = 8'h41 + {4'd0, nib - 4'd10};
            end else begin
                c = 8'h61 + {4'd0, nib - 4'd10};
            end
            return c;
        end
    endfunction

endpackage

@@ hdl/itfmt_dabble.sv @@
// One shift-and-add-3 step of the binary to BCD conversion.
`timescale 1ns / 1ps

module itfmt_dabble (
    input  logic [itfmt_pkg::C_DIG_W-1:0] i_bcd,
    input  logic                          i_bit,
    output logic [itfmt_pkg::C_DIG_W-1:0] o_bcd
);
    import itfmt_pkg::*;

    logic [C_DIG_W-1:0] adj;

    // Add three to every digit of five or more, then shift in the next bit
    always_comb begin
        for (int k = 0; k < C_DIGITS; k++) begin
            if (i_bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = i_bcd[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = i_bcd[4*k +: 4];
            end
        end
    end

    assign o_bcd = {adj[C_DIG_W-2:0], i_bit};

endmodule

@@ hdl/integer_to_ascii_formatter.sv @@
// Top level: sequencer that turns a 64-bit value into ASCII text, one character per strobe.
// Decimal mode: accept, convert the magnitude bit by bit to BCD, emit a minus sign if negative,
//   then scan the 20 digit positions, dropping leading zeros.
// Hex modes: accept, emit the two-character prefix in pointer mode, then scan 16 hex positions
//   from 20 slots. One BCD step unit serves the decimal conversion; start is ignored while busy.
// Results leave on o_valid for exactly one cycle each; the receiver cannot stall.
// Synchronous active-low reset returns the sequencer to idle and drops o_valid.
`timescale 1ns / 1ps

module integer_to_ascii_formatter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  itfmt_pkg::t_in   i_request,
    output logic             o_valid,
    output itfmt_pkg::t_out  o_result
);
    import itfmt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_PFX0 = 3'd2;
    localparam logic [2:0] S_PFX1 = 3'd3;
    localparam logic [2:0] S_DIGS = 3'd4;

    localparam logic [C_CNT_W-1:0] C_CONV_LAST = C_CNT_W'(C_BIN_W - 1);
    localparam logic [C_CNT_W-1:0] C_DIG_LAST  = C_CNT_W'(C_DIGITS - 1);

    logic [2:0]          r_state, n_state;
    logic [C_DIG_W-1:0]  r_dig,   n_dig;
    logic [C_BIN_W-1:0]  r_bin,   n_bin;
    logic [C_CNT_W-1:0]  r_cnt,   n_cnt;
    logic [1:0]          r_mode,  n_mode;
    logic                r_neg,   n_neg;
    logic                r_lead,  n_lead;
    logic                r_valid, n_valid;
    t_out                r_out,   n_out;

    logic [C_DIG_W-1:0]  dab_bcd;
    logic [C_BIN_W-1:0]  mag;
    logic [3:0]          nib;

    itfmt_dabble u_dabble (
        .i_bcd (r_dig),
        .i_bit (r_bin[C_BIN_W-1]),
        .o_bcd (dab_bcd)
    );

    assign busy = (r_state != S_IDLE);
    assign nib  = r_dig[C_DIG_W-1 -: 4];
    assign mag  = i_request.value[C_BIN_W-1] ? (~i_request.value + C_BIN_W'(1))
                                             : i_request.value;

    // Sequence conversion, prefix and digit emission
    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_bin   = r_bin;
        n_cnt   = r_cnt;
        n_mode  = r_mode;
        n_neg   = r_neg;
        n_lead  = r_lead;
        n_valid = 1'b0;
        n_out   = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode = i_request.mode;
                    n_lead = 1'b1;
                    if (i_request.mode == C_MODE_DEC) begin
                        n_neg   = i_request.value[C_BIN_W-1];
                        n_bin   = mag;
                        n_dig   = '0;
                        n_cnt   = C_CONV_LAST;
                        n_state = S_CONV;
                    end else begin
                        n_neg   = 1'b0;
                        n_dig   = {{(C_DIG_W-C_BIN_W){1'b0}}, i_request.value};
                        n_cnt   = C_DIG_LAST;
                        n_state = (i_request.mode == C_MODE_PTR) ? S_PFX0 : S_DIGS;
                    end
                end
            end
            S_CONV: begin
                n_dig = dab_bcd;
                n_bin = {r_bin[C_BIN_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_cnt   = C_DIG_LAST;
                    n_state = r_neg ? S_PFX0 : S_DIGS;
                end else begin
                    n_cnt = r_cnt - C_CNT_W'(1);
                end
            end
            S_PFX0: begin
                n_valid         = 1'b1;
                n_out.character = r_neg ? C_CHR_MINUS : C_CHR_ZERO;
                n_out.last      = 1'b0;
                n_state         = (r_mode == C_MODE_PTR) ? S_PFX1 : S_DIGS;
            end
            S_PFX1: begin
                n_valid         = 1'b1;
                n_out.character = C_CHR_X;
                n_out.last      = 1'b0;
                n_state         = S_DIGS;
            end
            S_DIGS: begin
                // drop leading zeros, but always emit the final digit
                if (!r_lead || nib != 4'd0 || r_cnt == '0) begin
                    n_valid         = 1'b1;
                    n_out.character = f_digit_char(nib, r_mode == C_MODE_HEXUP);
                    n_out.last      = (r_cnt == '0);
                end
                if (nib != 4'd0) begin
                    n_lead = 1'b0;
                end
                n_dig = {r_dig[C_DIG_W-5:0], 4'd0};
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - C_CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Register control state; reset returns it to idle and clears o_valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        r_dig  <= n_dig;
        r_bin  <= n_bin;
        r_cnt  <= n_cnt;
        r_mode <= n_mode;
        r_neg  <= n_neg;
        r_lead <= n_lead;
        r_out  <= n_out;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

@@ tb/sv/integer_to_ascii_formatter_tb.sv @@
// Testbench for the integer-to-ASCII formatter: directed and random requests checked per character.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;

    import itfmt_pkg::*;

    logic  i_clk     = 1'b0;
    logic  i_rst_n   = 1'b0;
    logic  start     = 1'b0;
    logic  busy;
    t_in   i_request = '0;
    logic  o_valid;
    t_out  o_result;

    t_in         request_queue [$];
    t_out        expected_chars [$];
    int unsigned n_issued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_errors   = 0;
    int unsigned idle_pct   = 0;

    integer_to_ascii_formatter i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_request (i_request),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

    // Free-running clock, 20 ns period
    always #10 i_clk = ~i_clk;

    // Work out the text of one request and queue its characters, most significant first
    function automatic void format_text(input t_in req);
        string       digit_set;
        logic [7:0]  text [$];
        logic [7:0]  rev [$];
        logic [63:0] mag;
        logic [63:0] radix;
        t_out        chr;
        digit_set = (req.mode == C_MODE_HEXUP) ? "0123456789ABCDEF" : "0123456789abcdef";
        mag       = req.value;
        radix     = 64'd16;
        if (req.mode == C_MODE_DEC) begin
            radix = 64'd10;
            // negate as unsigned, so the most negative value keeps its full magnitude
            if (req.value[63]) begin
                text.push_back(C_CHR_MINUS);
                mag = ~req.value + 64'd1;
            end
        end else if (req.mode == C_MODE_PTR) begin
            text.push_back(C_CHR_ZERO);
            text.push_back(C_CHR_X);
        end
        do begin
            rev.push_back(digit_set[int'(mag % radix)]);
            mag = mag / radix;
        end while (mag != 64'd0);
        while (rev.size() > 0) begin
            text.push_back(rev.pop_back());
        end
        foreach (text[k]) begin
            chr.character = text[k];
            chr.last      = (k == text.size() - 1);
            expected_chars.push_back(chr);
        end
    endfunction

    // Random value biased towards short texts, negatives and powers of two (or one below them)
    function automatic logic [63:0] make_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: begin
                v = v;
            end
            1: begin
                v = v >> $urandom_range(63);
            end
            2: begin
                v = ~(v >> $urandom_range(63));
            end
            default: begin
                v = 64'd1 << $urandom_range(63);
                if ($urandom_range(1)) v = v - 64'd1;
            end
        endcase
        return v;
    endfunction

    function automatic t_in make_request(input logic [1:0] mode, input logic [63:0] value);
        t_in r;
        r.mode  = mode;
        r.value = value;
        return r;
    endfunction

    // Driver: present the next request once the previous one has been taken
    always @(negedge i_clk) begin
        if (i_rst_n && n_accepted == n_issued) begin
            if (request_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_request <= request_queue.pop_front();
                start     <= 1'b1;
                n_issued  <= n_issued + 1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predict on each accepted request, check each strobed character
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            format_text(i_request);
            n_accepted <= n_accepted + 1;
        end
        if (o_valid === 1'b1) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character %h, last %b", o_result.character, o_result.last);
                n_errors <= n_errors + 1;
            end else begin
                if (o_result.character !== expected_chars[0].character ||
                    o_result.last !== expected_chars[0].last) begin
                    if (o_result.character !== expected_chars[0].character)
                        $error("character: expected %h, actual %h",
                               expected_chars[0].character, o_result.character);
                    if (o_result.last !== expected_chars[0].last)
                        $error("last: expected %b, actual %b",
                               expected_chars[0].last, o_result.last);
                    n_errors <= n_errors + 1;
                end
                void'(expected_chars.pop_front());
            end
        end
    end

    // Hold until every request is taken and every character has come back
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (request_queue.size() != 0 || start || expected_chars.size() != 0);
    endtask

    task automatic run_random(input int unsigned count, input int unsigned pct);
        idle_pct = pct;
        repeat (count) begin
            request_queue.push_back(make_request(2'($urandom_range(3)), make_value()));
        end
        drain();
    endtask

    // Stimulus and verdict
    initial begin
        logic [1:0] m;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero and all ones in every mode, sign extremes, digit boundaries
        for (int k = 0; k < 4; k++) begin
            m = 2'(k);
            request_queue.push_back(make_request(m, 64'd0));
            request_queue.push_back(make_request(m, 64'hFFFF_FFFF_FFFF_FFFF));
        end
        request_queue.push_back(make_request(C_MODE_DEC, 64'h8000_0000_0000_0000));
        request_queue.push_back(make_request(C_MODE_DEC, 64'h7FFF_FFFF_FFFF_FFFF));
        request_queue.push_back(make_request(C_MODE_DEC, 64'd9));
        request_queue.push_back(make_request(C_MODE_DEC, 64'd10));
        request_queue.push_back(make_request(C_MODE_DEC, 64'd1));
        request_queue.push_back(make_request(C_MODE_DEC, 64'd999_999_999_999_999_999));
        request_queue.push_back(make_request(C_MODE_HEXLO, 64'h0123_4567_89AB_CDEF));
        request_queue.push_back(make_request(C_MODE_HEXUP, 64'hFEDC_BA98_7654_3210));
        request_queue.push_back(make_request(C_MODE_HEXUP, 64'd15));
        request_queue.push_back(make_request(C_MODE_HEXLO, 64'd16));
        request_queue.push_back(make_request(C_MODE_PTR, 64'h0123_4567_89AB_CDEF));
        request_queue.push_back(make_request(C_MODE_PTR, 64'h8000_0000_0000_0000));
        drain();

        // Random phases: back-to-back, sender idle roughly half the time, then a fifth
        run_random(125, 0);
        run_random(125, 49);
        run_random(120, 21);

        repeat (200) @(posedge i_clk);
        #1;
        if (n_errors == 0 && expected_chars.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: end the run if the block stops answering
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/itfmt_pkg.sv
hdl/itfmt_dabble.sv
hdl/integer_to_ascii_formatter.sv
tb/sv/integer_to_ascii_formatter_tb.sv
